### hdl/utf8_path_name_validator_assert.svh
// Assertion macros for the path name validator.
// Expects signals clk and arst_n in the including scope.
`ifndef UTF8_PATH_NAME_VALIDATOR_ASSERT_SVH
`define UTF8_PATH_NAME_VALIDATOR_ASSERT_SVH

// condition holds at every edge outside reset
`define UPNV_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("upnv: invariant violated");

// trigger at this edge implies consequence at the next edge
`define UPNV_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("upnv: sequence violated");

`endif

### hdl/upnv_pkg.sv
// Shared types, constants and tables for the path name validator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package upnv_pkg;

	localparam int MAX_BRANCH_LEN = 128;

	// check modes
	typedef enum logic [1:0] {
		MODE_UTF8   = 2'd0,
		MODE_NAME   = 2'd1,
		MODE_REPO   = 2'd2,
		MODE_BRANCH = 2'd3
	} mode_t;

	// restriction on the first continuation byte
	typedef enum logic [2:0] {
		RULE_NONE   = 3'd0,
		RULE_GE_A0  = 3'd1,
		RULE_LT_A0  = 3'd2,
		RULE_GE_90  = 3'd3,
		RULE_LT_90  = 3'd4
	} rule_t;

	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_DOT       = 8'h2e;
	localparam logic [7:0] CH_DASH      = 8'h2d;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_DEL       = 8'h7f;
	localparam logic [7:0] CH_CTRL_MAX  = 8'h1f;

	localparam logic [2:0] HEAD_MISS = 3'd7;
	localparam logic [2:0] HEAD_FULL = 3'd4;

	// one input item
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	// per-string checker state
	typedef struct packed {
		logic [1:0] cont_left;
		rule_t      rule;
		logic       failed;
		logic [7:0] total_len;
		logic [1:0] comp_len;
		logic       comp_all_dots;
		logic       prev_was_dot;
		logic [2:0] head_match;
	} str_state_t;

	localparam str_state_t ST_CLEAR = '{
		cont_left:     2'd0,
		rule:          RULE_NONE,
		failed:        1'b0,
		total_len:     8'd0,
		comp_len:      2'd0,
		comp_all_dots: 1'b1,
		prev_was_dot:  1'b0,
		head_match:    3'd0
	};

	// letters of the reserved name HEAD
	function automatic logic [7:0] head_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h48;
			2'd1:    c = 8'h45;
			2'd2:    c = 8'h41;
			2'd3:    c = 8'h44;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// component empty, "." or ".."
	function automatic logic comp_bad(input logic [1:0] len, input logic all_dots);
		return (len == 2'd0) || ((len != 2'd3) && all_dots);
	endfunction

endpackage

`default_nettype wire

### hdl/upnv_in_reg.sv
// Input register stage: holds one accepted item until the checker takes it.
// Depends on upnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upnv_in_reg
	import upnv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire item_t in_item,
	input  wire logic  adv,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic load;

	// stall only while a held item cannot move on
	assign in_stall = valid_s1 & ~adv;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

### hdl/upnv_check.sv
// String checker: mode register, per-string state and the byte rules.
// Depends on upnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upnv_check
	import upnv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	input  wire logic       adv,
	input  wire item_t      item_s1,
	output logic            res_ok
);

	mode_t      mode_q;
	str_state_t st_q;
	str_state_t nx;
	logic [7:0] b;
	logic       first;
	logic       ctrl;
	logic       dot;
	logic       slash;
	logic       cont_ok;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UTF8;
		end else if (cfg_wr_en) begin
			mode_q <= mode_t'(cfg_wr_data);
		end
	end

	assign b     = item_s1.data_byte;
	assign first = (st_q.total_len == 8'd0);
	assign ctrl  = (b <= CH_CTRL_MAX) || (b == CH_DEL);
	assign dot   = (b == CH_DOT);
	assign slash = (b == CH_SLASH);

	// next state after the byte, and the verdict on the string
	always_comb begin
		nx      = st_q;
		cont_ok = 1'b1;
		if (item_s1.has_byte) begin
			// UTF-8 decoding
			if (st_q.cont_left != 2'd0) begin
				cont_ok = (b[7:6] == 2'b10);
				case (st_q.rule)
					RULE_GE_A0: if (b < 8'ha0) cont_ok = 1'b0;
					RULE_LT_A0: if (b >= 8'ha0) cont_ok = 1'b0;
					RULE_GE_90: if (b < 8'h90) cont_ok = 1'b0;
					RULE_LT_90: if (b >= 8'h90) cont_ok = 1'b0;
					default:    ;
				endcase
				if (!cont_ok) nx.failed = 1'b1;
				nx.cont_left = st_q.cont_left - 2'd1;
				nx.rule      = RULE_NONE;
			end else if (b <= 8'h7f) begin
				nx.cont_left = 2'd0;
			end else if (b inside {[8'hc2:8'hdf]}) begin
				nx.cont_left = 2'd1;
			end else if (b inside {[8'he0:8'hef]}) begin
				nx.cont_left = 2'd2;
				nx.rule = (b == 8'he0) ? RULE_GE_A0 : (b == 8'hed) ? RULE_LT_A0 : RULE_NONE;
			end else if (b inside {[8'hf0:8'hf4]}) begin
				nx.cont_left = 2'd3;
				nx.rule = (b == 8'hf0) ? RULE_GE_90 : (b == 8'hf4) ? RULE_LT_90 : RULE_NONE;
			end else begin
				nx.failed = 1'b1;
			end

			// byte rules of the mode
			case (mode_q)
				MODE_NAME: if (ctrl || slash) nx.failed = 1'b1;
				MODE_REPO: if (ctrl) nx.failed = 1'b1;
				MODE_BRANCH: begin
					if (ctrl || (b == CH_BACKSLASH)) nx.failed = 1'b1;
					if (dot && st_q.prev_was_dot) nx.failed = 1'b1;
					if (first && ((b == CH_DASH) || slash)) nx.failed = 1'b1;
				end
				default: ;
			endcase

			// components split on slash
			if (slash) begin
				if (((mode_q == MODE_REPO) || (mode_q == MODE_BRANCH)) &&
						comp_bad(st_q.comp_len, st_q.comp_all_dots))
					nx.failed = 1'b1;
				nx.comp_len      = 2'd0;
				nx.comp_all_dots = 1'b1;
			end else begin
				if (st_q.comp_len != 2'd3) nx.comp_len = st_q.comp_len + 2'd1;
				if (!dot) nx.comp_all_dots = 1'b0;
			end

			// exact HEAD tracking
			if ((st_q.total_len < 8'd4) && (st_q.head_match == st_q.total_len[2:0]) &&
					(b == head_char(st_q.total_len[1:0])))
				nx.head_match = st_q.head_match + 3'd1;
			else
				nx.head_match = HEAD_MISS;

			nx.prev_was_dot = dot;
			if (st_q.total_len != 8'hff) nx.total_len = st_q.total_len + 8'd1;
		end

		// closing checks
		res_ok = !nx.failed && (nx.cont_left == 2'd0);
		if ((mode_q != MODE_UTF8) && comp_bad(nx.comp_len, nx.comp_all_dots))
			res_ok = 1'b0;
		if (mode_q == MODE_BRANCH) begin
			if ((nx.total_len == 8'd0) || (nx.total_len > 8'(MAX_BRANCH_LEN)))
				res_ok = 1'b0;
			if (nx.prev_was_dot) res_ok = 1'b0;
			if (nx.head_match == HEAD_FULL) res_ok = 1'b0;
		end
	end

	// state moves with each item; a last item starts a fresh string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else if (adv) begin
			st_q <= item_s1.last ? ST_CLEAR : nx;
		end
	end

endmodule

`default_nettype wire

### hdl/upnv_out_reg.sv
// Result register: holds one verdict until the downstream side takes it.
// Depends on upnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upnv_out_reg
	import upnv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic res_ok,
	input  wire logic out_stall,
	output logic      out_free,
	output logic      out_valid_s2,
	output logic      res_s2
);

	// slot frees when empty or being taken this edge
	assign out_free = ~out_valid_s2 | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (load) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_ok;
		end
	end

endmodule

`default_nettype wire

### hdl/utf8_path_name_validator.sv
// An accepted item waits in the input register; a last item's verdict then goes
// to the result register. One byte item per cycle unless in_stall holds the input;
// the input register and the result register each hold one item, so input keeps flowing while a result waits.
// A last item stalls only while the result register is full and stalled.
// Reset (arst_n low, asynchronous) empties both registers, sets the mode
// to UTF-8 only and clears the string state.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_path_name_validator_assert.svh"

module utf8_path_name_validator
	import upnv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [1:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       has_byte,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            valid_res
);

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	logic  adv;
	logic  out_free;
	logic  res_ok;

	assign in_item = '{has_byte: has_byte, data_byte: data_byte, last: last};

	// held item moves on unless it needs the result slot and the slot is busy
	assign adv = valid_s1 & (~item_s1.last | out_free);

	upnv_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	upnv_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.adv         (adv),
		.item_s1     (item_s1),
		.res_ok      (res_ok)
	);

	upnv_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv & item_s1.last),
		.res_ok       (res_ok),
		.out_stall    (out_stall),
		.out_free     (out_free),
		.out_valid_s2 (out_valid),
		.res_s2       (valid_res)
	);

	// checks
	`UPNV_ASSERT_ALWAYS(a_stall_needs_item, !in_stall || valid_s1)
	`UPNV_ASSERT_NEXT(a_last_gives_result, adv && item_s1.last, out_valid)
	`UPNV_ASSERT_NEXT(a_last_waits_for_slot,
		valid_s1 && item_s1.last && out_valid && out_stall, valid_s1)

endmodule

`default_nettype wire
